FILE: rtl/scanline_sprite_unit_defines.svh
// assertion helpers for the scanline sprite unit
`ifndef SCANLINE_SPRITE_UNIT_DEFINES_SVH
`define SCANLINE_SPRITE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSU_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sprite unit check failed");
`define SSU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite unit check failed");
`define SSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite unit check failed");
`else
`define SSU_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SSU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ssu_pkg.sv
package ssu_pkg;

    localparam int SPRITE_COUNT_DEF = 64;
    localparam int LINE_SLOTS_DEF   = 8;
    localparam int LINE_TOTAL       = 262;

    // request kinds
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_EVAL   = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;
    localparam logic [1:0] ACT_RENDER = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TALL   = 2'd0;
    localparam logic [1:0] CFG_ENABLE = 2'd1;

    localparam int ATTR_FLIP_BIT   = 6;
    localparam int ATTR_BEHIND_BIT = 5;
    localparam logic [7:0] SPRITE_PIX_BASE = 8'h10;
    localparam logic [8:0] WIN_SHORT = 9'd8;
    localparam logic [8:0] WIN_TALL  = 9'd16;

    typedef struct packed {
        logic       covered;
        logic [2:0] col;
    } t_win_res;

endpackage

FILE: rtl/scanline_sprite_unit.sv
// Sprite unit for one scanline at a time. Every request yields one result. An attribute write
// or a pattern load goes from idle straight to the done state and the output register. A line
// evaluation walks the sprites through the single read port of the attribute memory: a sprite
// that misses the line or finds the list full is only compared, and a sprite placed in the
// line list also has its attribute and X bytes read. A pixel render checks one line slot a
// cycle in the shared window comparator. A result held back by the receiver adds its
// stall cycles before the next request can finish. The attribute memory has no reset; evaluate
// only after its sprites are written.
`include "scanline_sprite_unit_defines.svh"

module scanline_sprite_unit #(
    parameter int SPRITE_COUNT = ssu_pkg::SPRITE_COUNT_DEF,
    parameter int LINE_SLOTS   = ssu_pkg::LINE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // index, value, value_high, line, pixel_x, backdrop, zero pad
    input  logic [55:0] s_axis_tdata,
    // action
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_out, pixel_written, sprite_zero_hit, found_count, overflow, zero pad
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);

    localparam int SPR_W  = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(LINE_SLOTS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EV_CMP  = 3'd1;
    localparam logic [2:0] ST_EV_ATTR = 3'd2;
    localparam logic [2:0] ST_EV_X    = 3'd3;
    localparam logic [2:0] ST_PX      = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [1:0] in_action;
    logic [7:0] in_index;
    logic [7:0] in_value;
    logic [7:0] in_value_high;
    logic [8:0] in_line;
    logic [7:0] in_pixel_x;
    logic [7:0] in_backdrop;

    assign in_action     = s_axis_tuser;
    assign in_index      = s_axis_tdata[7:0];
    assign in_value      = s_axis_tdata[15:8];
    assign in_value_high = s_axis_tdata[23:16];
    assign in_line       = s_axis_tdata[32:24];
    assign in_pixel_x    = s_axis_tdata[40:33];
    assign in_backdrop   = s_axis_tdata[48:41];

    logic [2:0]       r_state, n_state;
    logic             r_tall;
    logic             r_en;
    logic [8:0]       r_next, n_next;
    logic [7:0]       r_px, n_px;
    logic [7:0]       r_bg, n_bg;
    logic [SPR_W-1:0] r_spr, n_spr;
    logic [CNT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_zero, n_zero;
    logic             r_ovf, n_ovf;
    logic [7:0]       r_pix, n_pix;
    logic             r_wr, n_wr;
    logic             r_hit, n_hit;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_data, n_out_data;
    logic [7:0]       r_mem_q;

    logic [7:0] r_attr_mem [0:255];
    logic [7:0] r_attr  [0:LINE_SLOTS-1];
    logic [7:0] r_xpos  [0:LINE_SLOTS-1];
    logic [7:0] r_plo   [0:LINE_SLOTS-1];
    logic [7:0] r_phi   [0:LINE_SLOTS-1];

    logic             w_take;
    logic             w_mem_we;
    logic             w_plane_we;
    logic             w_attr_we;
    logic             w_x_we;
    logic [7:0]       w_rd_addr;
    logic [9:0]       w_line_inc;
    logic [8:0]       w_next_line;
    logic [SPR_W-1:0] w_spr_inc;
    logic             w_spr_last;
    logic [SLOT_W-1:0] w_slot_idx;
    logic [SLOT_W-1:0] w_fill_idx;
    logic [8:0]       w_op_a;
    logic [7:0]       w_op_b;
    logic             w_win_tall;
    ssu_pkg::t_win_res w_win;
    logic [7:0]       w_attr_cur;
    logic [2:0]       w_col;
    logic [2:0]       w_sh;
    logic [1:0]       w_color;
    logic [CNT_W+3:0] w_count_ext;
    logic [3:0]       w_found;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // next line is (line + 1) mod 262; line + 1 stays below twice the frame height
    assign w_line_inc  = {1'b0, in_line} + 10'd1;
    assign w_next_line = (w_line_inc >= 10'(ssu_pkg::LINE_TOTAL))
                       ? 9'(w_line_inc - 10'(ssu_pkg::LINE_TOTAL)) : w_line_inc[8:0];

    assign w_spr_inc  = r_spr + 1'b1;
    assign w_spr_last = (r_spr == SPR_W'(SPRITE_COUNT - 1));
    assign w_slot_idx = r_slot[SLOT_W-1:0];
    assign w_fill_idx = r_count[SLOT_W-1:0];

    // shared window comparator: sprite y against next line, or pixel x against slot x
    assign w_op_a     = (r_state == ST_PX) ? {1'b0, r_px} : r_next;
    assign w_op_b     = (r_state == ST_PX) ? r_xpos[w_slot_idx] : r_mem_q;
    assign w_win_tall = (r_state == ST_PX) ? 1'b0 : r_tall;

    ssu_window_cmp u_win (
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .i_tall (w_win_tall),
        .o_res  (w_win)
    );

    assign w_attr_cur = r_attr[w_slot_idx];
    assign w_col      = w_attr_cur[ssu_pkg::ATTR_FLIP_BIT] ? ~w_win.col : w_win.col;
    assign w_sh       = ~w_col;
    assign w_color    = {r_phi[w_slot_idx][w_sh], r_plo[w_slot_idx][w_sh]};

    assign w_count_ext = {4'b0000, r_count};
    assign w_found     = w_count_ext[3:0];

    assign w_mem_we   = w_take && (in_action == ssu_pkg::ACT_WRITE);
    assign w_plane_we = w_take && (in_action == ssu_pkg::ACT_LOAD)
                     && (in_index < 8'(LINE_SLOTS));

    always_comb begin
        n_state     = r_state;
        n_next      = r_next;
        n_px        = r_px;
        n_bg        = r_bg;
        n_spr       = r_spr;
        n_slot      = r_slot;
        n_count     = r_count;
        n_zero      = r_zero;
        n_ovf       = r_ovf;
        n_pix       = r_pix;
        n_wr        = r_wr;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_rd_addr   = 8'({r_spr, 2'b00});
        w_attr_we   = 1'b0;
        w_x_we      = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_pix   = 8'h00;
                    n_wr    = 1'b0;
                    n_hit   = 1'b0;
                    n_state = ST_DONE;
                    case (in_action)
                        ssu_pkg::ACT_EVAL: begin
                            n_next    = w_next_line;
                            n_count   = '0;
                            n_zero    = 1'b0;
                            n_ovf     = 1'b0;
                            n_spr     = '0;
                            w_rd_addr = 8'h00;
                            n_state   = ST_EV_CMP;
                        end
                        ssu_pkg::ACT_RENDER: begin
                            n_px    = in_pixel_x;
                            n_bg    = in_backdrop;
                            n_pix   = in_backdrop;
                            n_slot  = '0;
                            n_state = ST_PX;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_EV_CMP: begin
                if (w_win.covered && (r_count < CNT_W'(LINE_SLOTS))) begin
                    w_rd_addr = 8'({r_spr, 2'b10});
                    n_state   = ST_EV_ATTR;
                end else begin
                    if (w_win.covered) begin
                        n_ovf = 1'b1;
                    end
                    if (w_spr_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_spr     = w_spr_inc;
                        w_rd_addr = 8'({w_spr_inc, 2'b00});
                    end
                end
            end
            ST_EV_ATTR: begin
                w_attr_we = 1'b1;
                w_rd_addr = 8'({r_spr, 2'b11});
                n_state   = ST_EV_X;
            end
            ST_EV_X: begin
                w_x_we  = 1'b1;
                n_count = r_count + 1'b1;
                if (r_spr == '0) begin
                    n_zero = 1'b1;
                end
                if (w_spr_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_spr     = w_spr_inc;
                    w_rd_addr = 8'({w_spr_inc, 2'b00});
                    n_state   = ST_EV_CMP;
                end
            end
            ST_PX: begin
                if (!r_en || (r_slot >= r_count)) begin
                    n_state = ST_DONE;
                end else if (w_win.covered && (w_color != 2'b00)) begin
                    // first opaque slot decides the pixel
                    if ((r_slot == '0) && r_zero && (r_bg != 8'h00)) begin
                        n_hit = 1'b1;
                    end
                    if (!w_attr_cur[ssu_pkg::ATTR_BEHIND_BIT] || (r_bg == 8'h00)) begin
                        n_pix = ssu_pkg::SPRITE_PIX_BASE | {4'b0000, w_attr_cur[1:0], w_color};
                        n_wr  = 1'b1;
                    end
                    n_state = ST_DONE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_ovf, w_found, r_hit, r_wr, r_pix};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tall      <= 1'b0;
            r_en        <= 1'b0;
            r_count     <= '0;
            r_zero      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_zero      <= n_zero;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ssu_pkg::CFG_TALL:   r_tall <= i_cfg_data;
                    ssu_pkg::CFG_ENABLE: r_en   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next     <= n_next;
        r_px       <= n_px;
        r_bg       <= n_bg;
        r_spr      <= n_spr;
        r_slot     <= n_slot;
        r_pix      <= n_pix;
        r_wr       <= n_wr;
        r_hit      <= n_hit;
        r_out_data <= n_out_data;
        if (w_attr_we) begin
            r_attr[w_fill_idx] <= r_mem_q;
        end
        if (w_x_we) begin
            r_xpos[w_fill_idx] <= r_mem_q;
        end
    end

    // pattern planes read as zero until loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINE_SLOTS; k++) begin
                r_plo[k] <= 8'h00;
                r_phi[k] <= 8'h00;
            end
        end else if (w_plane_we) begin
            r_plo[in_index[SLOT_W-1:0]] <= in_value;
            r_phi[in_index[SLOT_W-1:0]] <= in_value_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_attr_mem[in_index] <= in_value;
        end
        r_mem_q <= r_attr_mem[w_rd_addr];
    end

    `SSU_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(LINE_SLOTS))
    `SSU_ASSERT_IMPLIES(a_ovf_full, i_clk, i_rst_n, r_ovf, r_count == CNT_W'(LINE_SLOTS))
    `SSU_ASSERT_IMPLIES(a_zero_placed, i_clk, i_rst_n, r_zero, r_count != '0)
    `SSU_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_take, !s_axis_tready)

endmodule

FILE: rtl/ssu_window_cmp.sv
module ssu_window_cmp (
    input  logic [8:0]        i_op_a,
    input  logic [7:0]        i_op_b,
    input  logic              i_tall,
    output ssu_pkg::t_win_res o_res
);

    logic [9:0] w_diff;
    logic [8:0] w_limit;

    // a lies in [b, b + window) when a - b does not borrow and stays below the window
    assign w_diff  = {1'b0, i_op_a} - {2'b00, i_op_b};
    assign w_limit = i_tall ? ssu_pkg::WIN_TALL : ssu_pkg::WIN_SHORT;

    assign o_res.covered = !w_diff[9] && (w_diff[8:0] < w_limit);
    assign o_res.col     = w_diff[2:0];

endmodule

FILE: verif/scanline_sprite_unit_checker.sv
module scanline_sprite_unit_checker
    import ssu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [55:0] i_req_data,
    input  logic [1:0]  i_req_user,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_res_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] pixel;
        logic       written;
        logic       hit;
        logic [3:0] count;
        logic       ovf;
    } sprite_result_t;

    logic [7:0]     oam_bytes [256];
    logic [7:0]     line_sprites [LINE_SLOTS_DEF][4];
    logic [7:0]     pat_low [LINE_SLOTS_DEF];
    logic [7:0]     pat_high [LINE_SLOTS_DEF];
    int unsigned    line_fill;
    logic           sprite0_listed;
    logic           line_overflow;
    logic           mode_tall;
    logic           mode_enable;
    sprite_result_t due_results [$];
    int             error_tally = 0;

    function automatic void scan_line(input logic [8:0] cur_line);
        int unsigned tgt;
        int unsigned height;
        int unsigned y;
        tgt    = (int'(cur_line) + 1) % LINE_TOTAL;
        height = mode_tall ? WIN_TALL : WIN_SHORT;
        foreach (line_sprites[i, b]) line_sprites[i][b] = 8'hFF;
        line_fill      = 0;
        sprite0_listed = 1'b0;
        line_overflow  = 1'b0;
        for (int s = 0; s < SPRITE_COUNT_DEF; s++) begin
            y = oam_bytes[s * 4];
            if (tgt < y || tgt >= y + height) continue;
            if (line_fill < LINE_SLOTS_DEF) begin
                for (int b = 0; b < 4; b++) line_sprites[line_fill][b] = oam_bytes[s * 4 + b];
                if (s == 0) sprite0_listed = 1'b1;
                line_fill++;
            end else begin
                line_overflow = 1'b1;
            end
        end
    endfunction

    // lowest slot with an opaque pixel at this column decides, even when it sits behind
    function automatic sprite_result_t merge_pixel(input logic [7:0] px, input logic [7:0] bg);
        sprite_result_t r;
        int unsigned    sx;
        int unsigned    col;
        logic [7:0]     attr;
        logic [1:0]     color;
        r       = '0;
        r.pixel = bg;
        if (!mode_enable) return r;
        for (int i = 0; i < line_fill; i++) begin
            sx   = line_sprites[i][3];
            attr = line_sprites[i][2];
            if (px < sx || px - sx > 7) continue;
            col = px - sx;
            if (attr[ATTR_FLIP_BIT]) col = 7 - col;
            color = {pat_high[i][7 - col], pat_low[i][7 - col]};
            if (color == 2'b00) continue;
            if (i == 0 && sprite0_listed && bg != 8'd0) r.hit = 1'b1;
            if (!attr[ATTR_BEHIND_BIT] || bg == 8'd0) begin
                r.pixel   = SPRITE_PIX_BASE | {4'b0000, attr[1:0], color};
                r.written = 1'b1;
            end
            return r;
        end
        return r;
    endfunction

    task automatic check_field(input string label, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            error_tally++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        sprite_result_t want;
        sprite_result_t fresh;
        logic [7:0]     idx;
        if (!i_rst_n) begin
            foreach (oam_bytes[a]) oam_bytes[a] = 8'h00;
            foreach (line_sprites[i, b]) line_sprites[i][b] = 8'hFF;
            foreach (pat_low[i]) begin
                pat_low[i]  = 8'h00;
                pat_high[i] = 8'h00;
            end
            line_fill      = 0;
            sprite0_listed = 1'b0;
            line_overflow  = 1'b0;
            mode_tall      = 1'b0;
            mode_enable    = 1'b0;
            due_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with none expected, expected none actual %h",
                             $time, i_res_data);
                    error_tally++;
                end else begin
                    want = due_results.pop_front();
                    check_field("pixel_out", want.pixel, i_res_data[7:0]);
                    check_field("pixel_written", want.written, i_res_data[8]);
                    check_field("sprite_zero_hit", want.hit, i_res_data[9]);
                    check_field("found_count", want.count, i_res_data[13:10]);
                    check_field("overflow", want.ovf, i_res_data[14]);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TALL:   mode_tall = i_cfg_data;
                    CFG_ENABLE: mode_enable = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                idx   = i_req_data[7:0];
                fresh = '0;
                case (i_req_user)
                    ACT_WRITE: oam_bytes[idx] = i_req_data[15:8];
                    ACT_EVAL:  scan_line(i_req_data[32:24]);
                    ACT_LOAD: begin
                        // slots past the line list are dropped
                        if (idx < LINE_SLOTS_DEF) begin
                            pat_low[idx]  = i_req_data[15:8];
                            pat_high[idx] = i_req_data[23:16];
                        end
                    end
                    ACT_RENDER: fresh = merge_pixel(i_req_data[40:33], i_req_data[48:41]);
                    default: ;
                endcase
                fresh.count = line_fill[3:0];
                fresh.ovf   = line_overflow;
                due_results.push_back(fresh);
            end
        end
        o_pending <= due_results.size();
        o_errors  <= error_tally;
    end

endmodule

FILE: verif/scanline_sprite_unit_tb.sv
module scanline_sprite_unit_tb;
    import ssu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 45;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic [55:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = ACT_WRITE;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = CFG_TALL;
    logic        i_cfg_data    = 1'b0;

    int fault_count;
    int open_results;
    int send_idle    = 0;
    int stall_pct    = 0;
    int sent_items   = 0;
    int quiet_cycles = 0;
    bit cur_tall     = 1'b0;

    scanline_sprite_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    scanline_sprite_unit_checker i_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fault_count),
        .o_pending   (open_results)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("scanline_sprite_unit_tb: errors");
            $finish;
        end
    end

    // returns at the edge where the request was taken, tvalid still high
    task automatic issue(input logic [1:0] act, input int unsigned idx, input int unsigned val,
                         input int unsigned valh, input int unsigned line_no,
                         input int unsigned px, input int unsigned bg);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'b0, 8'(bg), 8'(px), 9'(line_no), 8'(valh), 8'(val), 8'(idx)};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic write_attr(input int unsigned idx, input int unsigned val);
        issue(ACT_WRITE, idx, val, $urandom_range(255), $urandom_range(511),
              $urandom_range(255), $urandom_range(255));
    endtask

    task automatic run_eval(input int unsigned line_no);
        issue(ACT_EVAL, $urandom_range(255), $urandom_range(255), $urandom_range(255), line_no,
              $urandom_range(255), $urandom_range(255));
    endtask

    task automatic load_slot(input int unsigned slot, input int unsigned lo,
                             input int unsigned hi);
        issue(ACT_LOAD, slot, lo, hi, $urandom_range(511), $urandom_range(255),
              $urandom_range(255));
    endtask

    task automatic render_px(input int unsigned px, input int unsigned bg);
        issue(ACT_RENDER, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              $urandom_range(511), px, bg);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_results != 0) @(posedge i_clk);
    endtask

    task automatic program_mode(input bit tall, input bit en);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TALL;
        i_cfg_data  <= tall;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= en;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_tall = tall;
    endtask

    // place a handful of sprites on one line, evaluate it, load patterns and draw over them
    task automatic sprite_scene();
        int unsigned tgt;
        int unsigned height;
        int unsigned s;
        int unsigned off;
        int unsigned y;
        logic [8:0]  cur_line;
        int unsigned slot;
        logic [7:0]  px;
        logic [7:0]  xs [$];
        cur_line = 9'($urandom_range(LINE_TOTAL - 1));
        tgt      = (cur_line + 1) % LINE_TOTAL;
        height   = cur_tall ? WIN_TALL : WIN_SHORT;
        repeat ($urandom_range(1, 12)) begin
            s   = ($urandom_range(3) == 0) ? 0 : $urandom_range(SPRITE_COUNT_DEF - 1);
            off = $urandom_range(height - 1);
            y   = (off > tgt) ? 0 : tgt - off;
            if (y > 255) y = 255;
            xs.push_back(8'($urandom_range(255)));
            write_attr(s * 4, y);
            write_attr(s * 4 + 2, $urandom_range(255));
            write_attr(s * 4 + 3, xs[$]);
        end
        // same next line reached from a line number past the frame
        if ($urandom_range(9) == 0 && cur_line < 250) cur_line = 9'(cur_line + LINE_TOTAL);
        run_eval(cur_line);
        repeat ($urandom_range(2, 6)) begin
            slot = ($urandom_range(11) == 0) ? $urandom_range(LINE_SLOTS_DEF, 255)
                                             : $urandom_range(LINE_SLOTS_DEF - 1);
            load_slot(slot, $urandom_range(255), $urandom_range(255));
        end
        repeat ($urandom_range(4, 8)) begin
            px = xs[$urandom_range(xs.size() - 1)] + 8'($urandom_range(7));
            render_px(px, ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic noise_burst();
        repeat (3) begin
            issue(2'($urandom_range(3)), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(511), $urandom_range(255),
                  $urandom_range(255));
        end
    endtask

    initial begin
        int  phase_end;
        bit  tall;
        bit  en;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_mode(1'b0, 1'b1);

        // whole attribute table first; Y bytes kept low on screen
        for (int a = 0; a < 256; a++) begin
            write_attr(a, (a % 4 == 0) ? $urandom_range(200, 255) : $urandom_range(255));
        end

        write_attr(0, 8'd20);
        write_attr(2, 8'h00);
        write_attr(3, 8'd0);
        run_eval(9'd19);
        load_slot(0, 8'hFF, 8'h00);
        render_px(8'd0, 8'd0);
        render_px(8'd7, 8'hFF);
        render_px(8'd8, 8'h80);
        // flipped, behind background, palette 3
        write_attr(2, 8'h63);
        run_eval(9'd19);
        load_slot(0, 8'h80, 8'h01);
        render_px(8'd0, 8'h42);
        render_px(8'd7, 8'd0);
        render_px(8'd3, 8'd0);
        load_slot(7, 8'h55, 8'hAA);
        load_slot(LINE_SLOTS_DEF, 8'hFF, 8'hFF);
        load_slot(8'hFF, 8'hFF, 8'hFF);
        run_eval(9'd261);
        run_eval(9'h1FF);
        render_px(8'hFF, 8'hFF);
        write_attr(8'hFF, 8'hFF);

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            tall = ((phase % 2) == 1);
            en   = (phase != 2 && phase != 5);
            program_mode(tall, en);
            case (phase % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 61; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 61; end
                default: begin send_idle = 10; stall_pct = 10; end
            endcase
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end) begin
                if ($urandom_range(9) == 0) noise_burst();
                else sprite_scene();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && open_results == 0) begin
            $display("scanline_sprite_unit_tb: clean");
        end else begin
            $display("scanline_sprite_unit_tb: errors");
        end
        $finish;
    end

endmodule

FILE: scanline_sprite_unit.f
+incdir+rtl
rtl/ssu_pkg.sv
rtl/ssu_window_cmp.sv
rtl/scanline_sprite_unit.sv
verif/scanline_sprite_unit_checker.sv
verif/scanline_sprite_unit_tb.sv
